/* src/vpma_pkg.sv */
// Shared types and constants for the planar video memory access unit.
package vpma_pkg;

    // Default number of plane memory address bits
    localparam int ADDR_BITS_DEFAULT = 16;

    // Configuration register indexes
    localparam logic [2:0] REG_PLANE_CONTROL  = 3'd0;
    localparam logic [2:0] REG_SET_RESET      = 3'd1;
    localparam logic [2:0] REG_COMPARE        = 3'd2;
    localparam logic [2:0] REG_ROTATE_FUNC    = 3'd3;
    localparam logic [2:0] REG_READ_PLANE     = 3'd4;
    localparam logic [2:0] REG_ACCESS_MODES   = 3'd5;
    localparam logic [2:0] REG_BIT_MASK       = 3'd6;

    // Write modes
    localparam logic [1:0] WMODE_ROTATE      = 2'd0;
    localparam logic [1:0] WMODE_LATCH       = 2'd1;
    localparam logic [1:0] WMODE_EXPAND      = 2'd2;
    localparam logic [1:0] WMODE_TRANSPARENT = 2'd3;

    // Logic functions
    localparam logic [1:0] LOGIC_COPY = 2'd0;
    localparam logic [1:0] LOGIC_AND  = 2'd1;
    localparam logic [1:0] LOGIC_OR   = 2'd2;
    localparam logic [1:0] LOGIC_XOR  = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_SECOND
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;       // capture item, read first address
        logic rd_second;    // read second address
        logic wr_first;     // write first address
        logic wr_second;    // write second address
        logic save_lo;      // keep low result byte of a word read
        logic finish_byte;  // load latch and output for a byte read
        logic finish_word;  // load latch and output for a word read
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_write;
        logic is_word;
        logic out_free;
    } t_status;

endpackage

/* src/vpma_ctrl.sv */
// Controller state machine sequencing reads and read-modify-writes.
module vpma_ctrl
    import vpma_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_FIRST;
                end
            end
            S_FIRST: begin
                if (i_status.is_write) begin
                    o_cmd.wr_first = 1'b1;
                    if (i_status.is_word) begin
                        o_cmd.rd_second = 1'b1;
                        n_state         = S_SECOND;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else if (i_status.is_word) begin
                    o_cmd.save_lo   = 1'b1;
                    o_cmd.rd_second = 1'b1;
                    n_state         = S_SECOND;
                end else if (i_status.out_free) begin
                    o_cmd.finish_byte = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SECOND: begin
                if (i_status.is_write) begin
                    o_cmd.wr_second = 1'b1;
                    n_state         = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.finish_word = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* src/vpma_datapath.sv */
// Datapath: plane memory, latch, configuration registers and output register.
module vpma_datapath
    import vpma_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDR_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic [1:0]  i_in_user,    // mode, word_access
    input  logic [31:0] i_in_data,    // address, host_data
    input  t_cmd        i_cmd,
    output t_status     o_status,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [15:0] o_out_data    // read_data
);

    localparam int DEPTH = 1 << ADDRESS_BITS;

    // Configuration registers
    logic [4:0] r_plane_control;
    logic [7:0] r_set_reset;
    logic [7:0] r_compare;
    logic [4:0] r_rotate_func;
    logic [1:0] r_read_plane;
    logic [3:0] r_access_modes;
    logic [7:0] r_bit_mask;

    // Item and working registers
    logic                    r_is_write;
    logic                    r_is_word;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic [15:0]             r_host_data;
    logic [31:0]             r_latch;
    logic [7:0]              r_lo_byte;
    logic                    r_out_valid;
    logic [15:0]             r_out_data;

    // Plane memory
    logic [31:0]             r_mem [0:DEPTH-1];
    logic [31:0]             r_rdata;

    logic [ADDRESS_BITS-1:0] addr_second;
    logic [ADDRESS_BITS-1:0] rd_addr;
    logic [ADDRESS_BITS-1:0] wr_addr;
    logic                    rd_en;
    logic                    wr_en;
    logic [7:0]              wr_byte;
    logic [31:0]             wr_word;
    logic [7:0]              rd_byte;

    function automatic logic [31:0] spread_nibble(input logic [3:0] n);
        logic [31:0] r;
        for (int p = 0; p < 4; p++) begin
            r[8*p +: 8] = {8{n[p]}};
        end
        return r;
    endfunction

    function automatic logic [7:0] rotr8(input logic [7:0] v, input logic [2:0] c);
        logic [15:0] d;
        d = {v, v} >> c;
        return d[7:0];
    endfunction

    function automatic logic [31:0] blend(input logic [31:0] keep,
                                          input logic [31:0] take,
                                          input logic [31:0] sel);
        return (keep & ~sel) | (take & sel);
    endfunction

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_control <= 5'd15;
            r_set_reset     <= 8'd0;
            r_compare       <= 8'd0;
            r_rotate_func   <= 5'd0;
            r_read_plane    <= 2'd0;
            r_access_modes  <= 4'd0;
            r_bit_mask      <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PLANE_CONTROL: r_plane_control <= i_cfg_data[4:0];
                REG_SET_RESET:     r_set_reset     <= i_cfg_data;
                REG_COMPARE:       r_compare       <= i_cfg_data;
                REG_ROTATE_FUNC:   r_rotate_func   <= i_cfg_data[4:0];
                REG_READ_PLANE:    r_read_plane    <= i_cfg_data[1:0];
                REG_ACCESS_MODES:  r_access_modes  <= i_cfg_data[3:0];
                REG_BIT_MASK:      r_bit_mask      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_is_write  <= i_in_user[0];
            r_is_word   <= i_in_user[1];
            r_addr      <= i_in_data[ADDRESS_BITS-1:0];
            r_host_data <= i_in_data[31:16];
        end
    end

    // Memory addressing; second address wraps
    assign addr_second = r_addr + ADDRESS_BITS'(1);
    assign rd_en       = i_cmd.accept | i_cmd.rd_second;
    assign rd_addr     = i_cmd.accept ? i_in_data[ADDRESS_BITS-1:0] : addr_second;
    assign wr_en       = i_cmd.wr_first | i_cmd.wr_second;
    assign wr_addr     = i_cmd.wr_second ? addr_second : r_addr;
    assign wr_byte     = i_cmd.wr_second ? r_host_data[15:8] : r_host_data[7:0];

    // Write modes, logic function, bit mask and plane enable
    always_comb begin
        logic [31:0] map;
        logic [31:0] sr;
        logic [31:0] esr;
        logic [31:0] rot_word;
        logic [31:0] nd;
        map      = spread_nibble(r_plane_control[3:0]);
        sr       = spread_nibble(r_set_reset[3:0]);
        esr      = spread_nibble(r_set_reset[7:4]);
        rot_word = {4{rotr8(wr_byte, r_rotate_func[2:0])}};
        nd       = '0;
        wr_word  = r_rdata;
        case (r_access_modes[1:0])
            WMODE_LATCH: begin
                wr_word = blend(r_rdata, r_latch, map);
            end
            WMODE_TRANSPARENT: begin
                nd      = (rot_word & sr) | (r_latch & ~sr);
                wr_word = blend(r_rdata, nd, map);
            end
            default: begin
                if (r_access_modes[1:0] == WMODE_ROTATE) begin
                    nd = blend(rot_word, sr, esr);
                end else if (r_plane_control[4]) begin
                    nd = {4{wr_byte}};
                end else begin
                    nd = spread_nibble(wr_byte[3:0]);
                end
                case (r_rotate_func[4:3])
                    LOGIC_AND: nd = nd & r_latch;
                    LOGIC_OR:  nd = nd | r_latch;
                    LOGIC_XOR: nd = nd ^ r_latch;
                    default:   nd = nd;
                endcase
                nd      = blend(r_latch, nd, {4{r_bit_mask}});
                wr_word = blend(r_rdata, nd, map);
            end
        endcase
    end

    // Plane memory with registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // Read mode 0 plane select or read mode 1 colour compare
    always_comb begin
        logic [31:0] t;
        t = (r_rdata ^ spread_nibble(r_compare[3:0])) & spread_nibble(r_compare[7:4]);
        if (r_access_modes[3]) begin
            rd_byte = ~(t[7:0] | t[15:8] | t[23:16] | t[31:24]);
        end else begin
            rd_byte = r_rdata[8*r_read_plane +: 8];
        end
    end

    // Keep the low byte of a word read
    always_ff @(posedge i_clk) begin
        if (i_cmd.save_lo) begin
            r_lo_byte <= rd_byte;
        end
    end

    // Latch takes the last word read by a read access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latch <= '0;
        end else if (i_cmd.finish_byte || i_cmd.finish_word) begin
            r_latch <= r_rdata;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish_byte || i_cmd.finish_word) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish_byte) begin
            r_out_data <= {8'd0, rd_byte};
        end else if (i_cmd.finish_word) begin
            r_out_data <= {rd_byte, r_lo_byte};
        end
    end

    assign o_status.is_write = r_is_write;
    assign o_status.is_word  = r_is_word;
    assign o_status.out_free = ~r_out_valid | i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

/* src/vga_planar_memory_access_unit.sv */
// Top level of the four-plane video memory access unit.
//
// Usage:
//   Slave stream carries CPU accesses: tuser holds mode (bit 0, 1 = write)
//   and word_access (bit 1); tdata holds address (15:0) and host_data (31:16).
//   Master stream returns read_data (tdata 15:0), one item per read access, none per
//   write. Configuration registers are written through i_cfg_we, i_cfg_index and i_cfg_data;
//   the user must write them only while no access is in flight; the block does not enforce it.
// Timing:
//   After acceptance a byte access passes through S_FIRST, a word access through
//   S_FIRST and S_SECOND, before the next item can be accepted; this order is set by
//   the simple dual-port plane memory, which gives one registered read and one
//   write per cycle and is walked once per addressed byte. A read result is loaded
//   into the output register from its last memory read once that register is free.
// Reset:
//   Synchronous, active low; clears the latch and the output valid flag and sets the
//   configuration registers to their defaults. The plane memory is not cleared.
// Stall:
//   A finished result waits in the output register; the next item is still
//   accepted, and only a later read waits until that register is taken.
module vga_planar_memory_access_unit
    import vpma_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDR_BITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // address[15:0], host_data[31:16]
    input  logic [1:0]  s_axis_tuser,   // mode[0], word_access[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // read_data[15:0]
);

    t_cmd    cmd;
    t_status status;

    vpma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    vpma_datapath #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_user   (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
